@@ hdl/qbpg_pkg.sv @@
// Package for the queued beep pattern generator.
// Holds the request, result and queue entry types and the shared codes.
// It depends on nothing else.
package qbpg_pkg;

  typedef struct packed {
    logic        op;
    logic [7:0]  pulse_count;
    logic [15:0] on_time;
    logic [15:0] off_time;
    logic        wants_notice;
  } in_item_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_QUEUED   = 3'd1,
    EV_FULL     = 3'd2,
    EV_DISABLED = 3'd3,
    EV_FINISHED = 3'd4
  } event_t;

  typedef struct packed {
    logic   buzzer_level;
    event_t event_res;
    logic   notice;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  pulse_count;
    logic [15:0] on_time;
    logic [15:0] off_time;
    logic        wants_notice;
  } queue_entry_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ON   = 3'b010,
    PH_OFF  = 3'b100
  } phase_t;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  localparam logic REG_ENABLED      = 1'b0;
  localparam logic REG_PIN_ATTACHED = 1'b1;

endpackage

@@ hdl/qbpg_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the request queue; it depends on no package.
module qbpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/queued_beep_pattern_generator.sv @@
// Top level of the queued beep pattern generator.
// Depends on qbpg_pkg for its types and on qbpg_ram for the request queue.
//
// Usage: the in_ channel carries both beep requests and one-millisecond ticks.
// A request is queued, or dropped when the block is disabled or the queue is
// full. Ticks pop the oldest request and time its on and off phases. Every
// accepted item yields exactly one result on the out_ channel, which reports
// the buzzer level after that item, the event and the notice flag.
// The APB-style port holds the enable register at address 0 and the pin
// attached register at address 4; writes take effect at the access cycle.
// The result sits in the output register on the cycle after acceptance.
// Throughput is one item per cycle while the receiver takes results; the
// queue head is read from the RAM at the next head address, and a request written to
// the slot being read is forwarded around the RAM.
// A stalled receiver holds the output register; in_ready stays high while the
// held result is taken in the same cycle.
// Reset empties the queue, idles the player, drives the buzzer low, sets
// enabled and clears pin attached. No clearing pass over the queue is needed.
module queued_beep_pattern_generator #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  qbpg_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output qbpg_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import qbpg_pkg::*;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W  = $bits(queue_entry_t);
  localparam logic [PTR_W-1:0]  LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);

  logic              enabled_r, enabled_nxt;
  logic              pin_r, pin_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  phase_t            phase_r, phase_nxt;
  logic [15:0]       rem_r, rem_nxt;
  logic [7:0]        beeps_r, beeps_nxt;
  logic [7:0]        beeps_dec;
  logic [15:0]       cur_on_r, cur_on_nxt;
  logic [15:0]       cur_off_r, cur_off_nxt;
  logic              cur_notice_r, cur_notice_nxt;
  logic              level_r, level_nxt;
  logic              fwd_r, fwd_nxt;
  queue_entry_t      fwd_data_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              in_fire;
  logic              cfg_wr;
  logic              we;
  queue_entry_t      wentry;
  queue_entry_t      head_ent;
  logic [ENT_W-1:0]  ram_rdata;
  event_t            ev;
  logic              nt;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign beeps_dec = beeps_r - 8'd1;

  assign wentry.pulse_count  = in_data.pulse_count;
  assign wentry.on_time      = in_data.on_time;
  assign wentry.off_time     = in_data.off_time;
  assign wentry.wants_notice = in_data.wants_notice;

  assign head_ent = fwd_r ? fwd_data_r : queue_entry_t'(ram_rdata);

  always_comb begin
    unique case (paddr[2])
      REG_ENABLED:      prdata = {31'd0, enabled_r};
      REG_PIN_ATTACHED: prdata = {31'd0, pin_r};
      default:          prdata = 32'd0;
    endcase
  end

  always_comb begin
    enabled_nxt    = enabled_r;
    pin_nxt        = pin_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    fill_nxt       = fill_r;
    phase_nxt      = phase_r;
    rem_nxt        = rem_r;
    beeps_nxt      = beeps_r;
    cur_on_nxt     = cur_on_r;
    cur_off_nxt    = cur_off_r;
    cur_notice_nxt = cur_notice_r;
    level_nxt      = level_r;
    we             = 1'b0;
    ev             = EV_NONE;
    nt             = 1'b0;

    if (in_fire) begin
      if (in_data.op == OP_REQUEST) begin
        if (!enabled_r) begin
          ev = EV_DISABLED;
          nt = in_data.wants_notice;
        end else if (fill_r >= FULL_FILL) begin
          ev = EV_FULL;
          nt = in_data.wants_notice;
        end else begin
          we       = 1'b1;
          tail_nxt = (tail_r == LAST_SLOT) ? '0 : tail_r + PTR_W'(1);
          fill_nxt = fill_r + FILL_W'(1);
          ev       = EV_QUEUED;
        end
      end else if (phase_r == PH_IDLE) begin
        if (fill_r != '0) begin
          head_nxt       = (head_r == LAST_SLOT) ? '0 : head_r + PTR_W'(1);
          fill_nxt       = fill_r - FILL_W'(1);
          cur_on_nxt     = head_ent.on_time;
          cur_off_nxt    = head_ent.off_time;
          cur_notice_nxt = head_ent.wants_notice;
          if (head_ent.pulse_count == 8'd0 || !enabled_r || !pin_r) begin
            level_nxt = 1'b0;
            phase_nxt = PH_IDLE;
            rem_nxt   = '0;
            beeps_nxt = '0;
            ev        = EV_FINISHED;
            nt        = head_ent.wants_notice;
          end else begin
            beeps_nxt = head_ent.pulse_count;
            phase_nxt = PH_ON;
            rem_nxt   = head_ent.on_time;
            level_nxt = 1'b1;
          end
        end
      end else if (rem_r > 16'd1) begin
        rem_nxt = rem_r - 16'd1;
      end else if (phase_r == PH_ON) begin
        if (beeps_dec == 8'd0) begin
          level_nxt = 1'b0;
          phase_nxt = PH_IDLE;
          rem_nxt   = '0;
          beeps_nxt = '0;
          ev        = EV_FINISHED;
          nt        = cur_notice_r;
        end else begin
          beeps_nxt = beeps_dec;
          phase_nxt = PH_OFF;
          rem_nxt   = cur_off_r;
          level_nxt = 1'b0;
        end
      end else begin
        phase_nxt = PH_ON;
        rem_nxt   = cur_on_r;
        level_nxt = 1'b1;
      end
    end

    if (cfg_wr) begin
      unique case (paddr[2])
        REG_ENABLED: begin
          enabled_nxt = pwdata[0];
          if (!pwdata[0]) begin
            level_nxt = 1'b0;
          end
        end
        REG_PIN_ATTACHED: pin_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  assign fwd_nxt = we && (tail_r == head_nxt);

  qbpg_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (we),
    .waddr (tail_r),
    .wdata (ENT_W'(wentry)),
    .raddr (head_nxt),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b1;
      pin_r       <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      phase_r     <= PH_IDLE;
      rem_r       <= '0;
      beeps_r     <= '0;
      level_r     <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      enabled_r <= enabled_nxt;
      pin_r     <= pin_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      fill_r    <= fill_nxt;
      phase_r   <= phase_nxt;
      rem_r     <= rem_nxt;
      beeps_r   <= beeps_nxt;
      level_r   <= level_nxt;
      fwd_r     <= fwd_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_on_r     <= cur_on_nxt;
    cur_off_r    <= cur_off_nxt;
    cur_notice_r <= cur_notice_nxt;
    fwd_data_r   <= wentry;
    if (in_fire) begin
      out_data_r.buzzer_level <= level_nxt;
      out_data_r.event_res    <= ev;
      out_data_r.notice       <= nt;
    end
  end

  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_FILL)
    else $error("queue fill count exceeds the queue depth");

  a_idle_low : assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> !level_r)
    else $error("buzzer driven high while the player is idle");

  a_empty_ptrs : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == '0 |-> head_r == tail_r)
    else $error("empty queue with head and tail apart");

  a_full_drop : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.op == OP_REQUEST && enabled_r && fill_r == FULL_FILL
    |=> out_valid && out_data_r.event_res == EV_FULL)
    else $error("request into a full queue not reported as dropped");

endmodule
